// File: src/assert_macros.svh
// Assertion macros used by the checker file of the byte execute unit.
// Needs nothing else; take it in by include ahead of the module text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BIE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BIE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check what the cycle after a reset cycle shows.
`define BIE_ASSERT_RST(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bie_pkg.sv
// Shared types, codes and constants of the byte execute unit.
// No dependencies; the design and checker files refer to it by scoped names.
package bie_pkg;

   localparam int REG_COUNT   = 16;
   localparam int MEM_DEPTH   = 256;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [7:0] HALT_PC = 8'hFF;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 48;

   // Bit positions of the result fields in rsp_tdata.
   localparam int RSP_NPC_LSB   = 0;
   localparam int RSP_HALT_BIT  = 8;
   localparam int RSP_ILL_BIT   = 9;
   localparam int RSP_RW_BIT    = 10;
   localparam int RSP_RDST_LSB  = 11;
   localparam int RSP_RVAL_LSB  = 19;
   localparam int RSP_MW_BIT    = 27;
   localparam int RSP_MADDR_LSB = 28;
   localparam int RSP_MVAL_LSB  = 36;

   typedef enum logic [4:0] {
      OP_ADD1   = 5'd0,
      OP_ADD2   = 5'd1,
      OP_AND1   = 5'd2,
      OP_AND2   = 5'd3,
      OP_OR1    = 5'd4,
      OP_OR2    = 5'd5,
      OP_BEQ1   = 5'd6,
      OP_BEQ2   = 5'd7,
      OP_BEQ3   = 5'd8,
      OP_BEQ4   = 5'd9,
      OP_JUMP1  = 5'd10,
      OP_JUMP2  = 5'd11,
      OP_MOVE1  = 5'd12,
      OP_MOVE2  = 5'd13,
      OP_SHL1   = 5'd14,
      OP_SHL2   = 5'd15,
      OP_SHR1   = 5'd16,
      OP_SHR2   = 5'd17,
      OP_LOAD1  = 5'd18,
      OP_LOAD2  = 5'd19,
      OP_STORE1 = 5'd20,
      OP_STORE2 = 5'd21
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_ALU,
      KIND_BRANCH,
      KIND_LOAD,
      KIND_STORE,
      KIND_ILLEGAL
   } kind_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_AND,
      ALU_OR,
      ALU_MOVE,
      ALU_SHL,
      ALU_SHR
   } alu_type;

   typedef enum logic [1:0] {
      TGT_RC,
      TGT_C,
      TGT_RA,
      TGT_A
   } tgt_type;

   // Classified instruction as it travels from front to back.
   typedef struct packed {
      kind_type   kind;
      alu_type    alu;
      logic       src1_imm;      // first ALU operand is b, not reg[b]
      logic       src2_imm;      // second ALU operand is c, not reg[c]
      logic       cmp_imm;       // compare reg[a] with b, not reg[b]
      logic       always_taken;  // jump
      tgt_type    tgt;
      logic       addr_imm;      // memory address is b, not reg[b]
      logic [7:0] arg_a;
      logic [7:0] arg_b;
      logic [7:0] arg_c;
      logic [7:0] idx_a;         // register indexes reduced to the file size
      logic [7:0] idx_b;
      logic [7:0] idx_c;
   } instr_type;

   // One result, last field in the lowest bits.
   typedef struct packed {
      logic [7:0] mem_value;
      logic [7:0] mem_address;
      logic       mem_written;
      logic [7:0] reg_value;
      logic [7:0] reg_dest;
      logic       reg_written;
      logic       illegal_op;
      logic       halted;
      logic [7:0] next_pc;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   typedef logic [255:0][7:0] rix_table_type;

   // Byte value to register index, wrapping at count; built at elaboration.
   function automatic rix_table_type rix_table(input int count);
      rix_table_type t;
      int            r;
      r = 0;
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'(r);
         r = (r == count - 1) ? 0 : r + 1;
      end
      return t;
   endfunction

endpackage

// File: src/byte_isa_execute_unit.sv
// Path: a result shows on rsp_tvalid once its item has passed the queue write,
// register read, memory access and then the result register.
// Throughput: one item per cycle while rsp_tready is high; operands forward past
// the two stages ahead. Reset: synchronous, active high; clears pc, queue, stage
// valids and the valid bits of register file and data memory, no clearing pass.
module byte_isa_execute_unit #(
   parameter int REG_COUNT   = bie_pkg::REG_COUNT,
   parameter int QUEUE_DEPTH = bie_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // Instruction items
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] arg_first, [15:8] arg_second, [23:16] arg_third
   input  logic [bie_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [4:0] req_type
   input  logic [bie_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Result items
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] next_pc, [8] halted, [9] illegal_op, [10] reg_written,
   // [18:11] reg_dest, [26:19] reg_value, [27] mem_written,
   // [35:28] mem_address, [43:36] mem_value, [47:44] zero
   output logic [bie_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   bie_pkg::instr_type  front_item;
   bie_pkg::instr_type  queue_item;
   logic                queue_valid;
   logic                back_ready;
   bie_pkg::result_type result;

   // Classify the incoming instruction.
   bie_front #(
      .REG_COUNT (REG_COUNT)
   ) u_front (
      .req_type   (req_tuser[4:0]),
      .arg_first  (req_tdata[7:0]),
      .arg_second (req_tdata[15:8]),
      .arg_third  (req_tdata[23:16]),
      .instr      (front_item)
   );

   // Decouple acceptance from execution; the input stalls only when full.
   bie_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_item  (queue_item)
   );

   // Execute, commit state and hold the result until taken.
   bie_back #(
      .REG_COUNT (REG_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (back_ready),
      .in_item    (queue_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Pad the result fields up to whole bytes.
   assign rsp_tdata = {{(bie_pkg::RSP_TDATA_W - bie_pkg::RESULT_W){1'b0}}, result};

endmodule

// File: src/bie_front.sv
// Front end of the byte execute unit: decodes one instruction item.
// Uses bie_pkg for opcode codes, the classified item type and the index table.
module bie_front #(
   parameter int REG_COUNT = bie_pkg::REG_COUNT
) (
   input  logic [4:0]          req_type,
   input  logic [7:0]          arg_first,
   input  logic [7:0]          arg_second,
   input  logic [7:0]          arg_third,
   output bie_pkg::instr_type  instr
);

   localparam bie_pkg::rix_table_type RIX = bie_pkg::rix_table(REG_COUNT);

   always_comb begin
      instr              = '0;
      instr.kind         = bie_pkg::KIND_ILLEGAL;
      instr.alu          = bie_pkg::ALU_ADD;
      instr.tgt          = bie_pkg::TGT_RC;
      instr.arg_a        = arg_first;
      instr.arg_b        = arg_second;
      instr.arg_c        = arg_third;
      instr.idx_a        = RIX[arg_first];
      instr.idx_b        = RIX[arg_second];
      instr.idx_c        = RIX[arg_third];
      unique case (bie_pkg::opcode_type'(req_type))
         bie_pkg::OP_ADD1: begin
            instr.kind = bie_pkg::KIND_ALU;
         end
         bie_pkg::OP_ADD2: begin
            instr.kind     = bie_pkg::KIND_ALU;
            instr.src2_imm = 1'b1;
         end
         bie_pkg::OP_AND1: begin
            instr.kind = bie_pkg::KIND_ALU;
            instr.alu  = bie_pkg::ALU_AND;
         end
         bie_pkg::OP_AND2: begin
            instr.kind     = bie_pkg::KIND_ALU;
            instr.alu      = bie_pkg::ALU_AND;
            instr.src2_imm = 1'b1;
         end
         bie_pkg::OP_OR1: begin
            instr.kind = bie_pkg::KIND_ALU;
            instr.alu  = bie_pkg::ALU_OR;
         end
         bie_pkg::OP_OR2: begin
            instr.kind     = bie_pkg::KIND_ALU;
            instr.alu      = bie_pkg::ALU_OR;
            instr.src2_imm = 1'b1;
         end
         bie_pkg::OP_BEQ1: begin
            instr.kind = bie_pkg::KIND_BRANCH;
         end
         bie_pkg::OP_BEQ2: begin
            instr.kind = bie_pkg::KIND_BRANCH;
            instr.tgt  = bie_pkg::TGT_C;
         end
         bie_pkg::OP_BEQ3: begin
            instr.kind    = bie_pkg::KIND_BRANCH;
            instr.cmp_imm = 1'b1;
         end
         bie_pkg::OP_BEQ4: begin
            instr.kind    = bie_pkg::KIND_BRANCH;
            instr.cmp_imm = 1'b1;
            instr.tgt     = bie_pkg::TGT_C;
         end
         bie_pkg::OP_JUMP1: begin
            instr.kind         = bie_pkg::KIND_BRANCH;
            instr.always_taken = 1'b1;
            instr.tgt          = bie_pkg::TGT_RA;
         end
         bie_pkg::OP_JUMP2: begin
            instr.kind         = bie_pkg::KIND_BRANCH;
            instr.always_taken = 1'b1;
            instr.tgt          = bie_pkg::TGT_A;
         end
         bie_pkg::OP_MOVE1: begin
            instr.kind = bie_pkg::KIND_ALU;
            instr.alu  = bie_pkg::ALU_MOVE;
         end
         bie_pkg::OP_MOVE2: begin
            instr.kind     = bie_pkg::KIND_ALU;
            instr.alu      = bie_pkg::ALU_MOVE;
            instr.src1_imm = 1'b1;
         end
         bie_pkg::OP_SHL1: begin
            instr.kind = bie_pkg::KIND_ALU;
            instr.alu  = bie_pkg::ALU_SHL;
         end
         bie_pkg::OP_SHL2: begin
            instr.kind     = bie_pkg::KIND_ALU;
            instr.alu      = bie_pkg::ALU_SHL;
            instr.src2_imm = 1'b1;
         end
         bie_pkg::OP_SHR1: begin
            instr.kind = bie_pkg::KIND_ALU;
            instr.alu  = bie_pkg::ALU_SHR;
         end
         bie_pkg::OP_SHR2: begin
            instr.kind     = bie_pkg::KIND_ALU;
            instr.alu      = bie_pkg::ALU_SHR;
            instr.src2_imm = 1'b1;
         end
         bie_pkg::OP_LOAD1: begin
            instr.kind = bie_pkg::KIND_LOAD;
         end
         bie_pkg::OP_LOAD2: begin
            instr.kind     = bie_pkg::KIND_LOAD;
            instr.addr_imm = 1'b1;
         end
         bie_pkg::OP_STORE1: begin
            instr.kind = bie_pkg::KIND_STORE;
         end
         bie_pkg::OP_STORE2: begin
            instr.kind     = bie_pkg::KIND_STORE;
            instr.addr_imm = 1'b1;
         end
         default: begin
            instr.kind = bie_pkg::KIND_ILLEGAL;
         end
      endcase
   end

endmodule

// File: src/bie_queue.sv
// Short queue of classified instructions between front and back end.
// Uses bie_pkg for the item type and the default depth.
module bie_queue #(
   parameter int DEPTH = bie_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bie_pkg::instr_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output bie_pkg::instr_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bie_pkg::instr_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: src/bie_back.sv
// Back end of the byte execute unit: register read, execute, memory, commit.
// Holds the register file, data memory and program counter; uses bie_pkg.
module bie_back #(
   parameter int REG_COUNT = bie_pkg::REG_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bie_pkg::instr_type  in_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bie_pkg::result_type rsp_result
);

   localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic       illegal;
      logic       rwe;
      logic       is_load;
      idx_type    dest;
      logic [7:0] alu;
      logic       mwe;
      logic [7:0] maddr;
      logic [7:0] mval;
      logic       taken;
      logic [7:0] target;
   } wstage_type;

   // Register file kept twice so three operands read in the same cycle.
   logic [7:0]          bank0_mem [REG_COUNT];
   logic [7:0]          bank1_mem [REG_COUNT];
   logic [REG_COUNT-1:0] rvalid_ff;
   logic [7:0]          dmem_mem [bie_pkg::MEM_DEPTH];
   logic [bie_pkg::MEM_DEPTH-1:0] mvalid_ff;
   logic [7:0]          pc_ff;

   // Execute stage
   logic                e_vld_ff, e_vld_in;
   bie_pkg::instr_type  e_item_ff;
   logic [7:0]          raw_ff [3];
   logic [2:0]          rdv_ff;
   logic [2:0]          ovr_ff;
   logic [7:0]          ovr_data_ff [3];

   // Memory / writeback stage
   logic                w_vld_ff, w_vld_in;
   wstage_type          w_ff, w_in;
   logic [7:0]          mraw_ff;
   logic                mrdv_ff;
   logic                movr_ff;
   logic [7:0]          movr_data_ff;

   logic                rsp_vld_ff, rsp_vld_in;
   bie_pkg::result_type rsp_ff, rsp_in;

   logic                out_free, w_free, e_free, w_move, e_move, pop;
   idx_type             q_idx [3];
   idx_type             e_idx [3];
   logic [7:0]          opnd [3];
   logic [7:0]          src1, src2, cmp_val, alu_res, target, maddr;
   logic                taken;
   logic [7:0]          w_mdata, w_rval, npc;
   logic                cm_rwe, cm_mwe;

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign w_free   = !w_vld_ff || out_free;
   assign w_move   = w_vld_ff && out_free;
   assign e_free   = !e_vld_ff || w_free;
   assign e_move   = e_vld_ff && w_free;
   assign in_ready = e_free;
   assign pop      = in_valid && e_free;

   assign cm_rwe = w_move && w_ff.rwe;
   assign cm_mwe = w_move && w_ff.mwe;

   assign q_idx[0] = in_item.idx_a[IDX_W-1:0];
   assign q_idx[1] = in_item.idx_b[IDX_W-1:0];
   assign q_idx[2] = in_item.idx_c[IDX_W-1:0];
   assign e_idx[0] = e_item_ff.idx_a[IDX_W-1:0];
   assign e_idx[1] = e_item_ff.idx_b[IDX_W-1:0];
   assign e_idx[2] = e_item_ff.idx_c[IDX_W-1:0];

   // Operand value: pending write in the next stage first, then a write
   // caught while waiting, then the file itself (unwritten entries read 0).
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (w_vld_ff && w_ff.rwe && (w_ff.dest == e_idx[k])) begin
            opnd[k] = w_rval;
         end else if (ovr_ff[k]) begin
            opnd[k] = ovr_data_ff[k];
         end else if (rdv_ff[k]) begin
            opnd[k] = raw_ff[k];
         end else begin
            opnd[k] = 8'd0;
         end
      end
   end

   always_comb begin
      src1    = e_item_ff.src1_imm ? e_item_ff.arg_b : opnd[1];
      src2    = e_item_ff.src2_imm ? e_item_ff.arg_c : opnd[2];
      cmp_val = e_item_ff.cmp_imm ? e_item_ff.arg_b : opnd[1];
      maddr   = e_item_ff.addr_imm ? e_item_ff.arg_b : opnd[1];
      unique case (e_item_ff.alu)
         bie_pkg::ALU_ADD:  alu_res = src1 + src2;
         bie_pkg::ALU_AND:  alu_res = src1 & src2;
         bie_pkg::ALU_OR:   alu_res = src1 | src2;
         bie_pkg::ALU_MOVE: alu_res = src1;
         bie_pkg::ALU_SHL:  alu_res = (src2 > 8'd7) ? 8'd0 : (src1 << src2[2:0]);
         bie_pkg::ALU_SHR:  alu_res = (src2 > 8'd7) ? 8'd0 : (src1 >> src2[2:0]);
         default:           alu_res = 8'd0;
      endcase
      unique case (e_item_ff.tgt)
         bie_pkg::TGT_RC: target = opnd[2];
         bie_pkg::TGT_C:  target = e_item_ff.arg_c;
         bie_pkg::TGT_RA: target = opnd[0];
         bie_pkg::TGT_A:  target = e_item_ff.arg_a;
         default:         target = opnd[2];
      endcase
      taken = (e_item_ff.kind == bie_pkg::KIND_BRANCH)
              && (e_item_ff.always_taken || (opnd[0] == cmp_val));

      w_in.illegal = (e_item_ff.kind == bie_pkg::KIND_ILLEGAL);
      w_in.rwe     = (e_item_ff.kind == bie_pkg::KIND_ALU)
                     || (e_item_ff.kind == bie_pkg::KIND_LOAD);
      w_in.is_load = (e_item_ff.kind == bie_pkg::KIND_LOAD);
      w_in.dest    = e_idx[0];
      w_in.alu     = alu_res;
      w_in.mwe     = (e_item_ff.kind == bie_pkg::KIND_STORE);
      w_in.maddr   = maddr;
      w_in.mval    = opnd[0];
      w_in.taken   = taken;
      w_in.target  = target;
   end

   // Writeback stage: load data, next pc, result fields.
   always_comb begin
      w_mdata = movr_ff ? movr_data_ff : (mrdv_ff ? mraw_ff : 8'd0);
      w_rval  = w_ff.is_load ? w_mdata : w_ff.alu;
      if (w_ff.illegal) begin
         npc = pc_ff;
      end else if (w_ff.taken) begin
         npc = w_ff.target;
      end else begin
         npc = pc_ff + 8'd1;
      end
      rsp_in.next_pc     = npc;
      rsp_in.halted      = (npc == bie_pkg::HALT_PC);
      rsp_in.illegal_op  = w_ff.illegal;
      rsp_in.reg_written = w_ff.rwe;
      rsp_in.reg_dest    = w_ff.rwe ? 8'(w_ff.dest) : 8'd0;
      rsp_in.reg_value   = w_ff.rwe ? w_rval : 8'd0;
      rsp_in.mem_written = w_ff.mwe;
      rsp_in.mem_address = w_ff.mwe ? w_ff.maddr : 8'd0;
      rsp_in.mem_value   = w_ff.mwe ? w_ff.mval : 8'd0;
   end

   always_comb begin
      e_vld_in   = e_free ? pop : e_vld_ff;
      w_vld_in   = w_free ? e_vld_ff : w_vld_ff;
      rsp_vld_in = out_free ? w_vld_ff : rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff   <= 1'b0;
         w_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         pc_ff      <= 8'd0;
         rvalid_ff  <= '0;
         mvalid_ff  <= '0;
      end else begin
         e_vld_ff   <= e_vld_in;
         w_vld_ff   <= w_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (w_move) begin
            pc_ff <= npc;
         end
         if (cm_rwe) begin
            rvalid_ff[w_ff.dest] <= 1'b1;
         end
         if (cm_mwe) begin
            mvalid_ff[w_ff.maddr] <= 1'b1;
         end
      end
   end

   // Register file banks: write at commit.
   always_ff @(posedge clock) begin
      if (cm_rwe) begin
         bank0_mem[w_ff.dest] <= w_rval;
         bank1_mem[w_ff.dest] <= w_rval;
      end
   end

   // Register read as an item enters the execute stage.
   always_ff @(posedge clock) begin
      if (pop) begin
         e_item_ff <= in_item;
         raw_ff[0] <= bank0_mem[q_idx[0]];
         raw_ff[1] <= bank0_mem[q_idx[1]];
         raw_ff[2] <= bank1_mem[q_idx[2]];
         for (int k = 0; k < 3; k++) begin
            rdv_ff[k] <= rvalid_ff[q_idx[k]];
         end
      end
   end

   // Catch commits that the registered read misses or that land while waiting.
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (pop) begin
            ovr_ff[k]      <= cm_rwe && (w_ff.dest == q_idx[k]);
            ovr_data_ff[k] <= w_rval;
         end else if (e_vld_ff && cm_rwe && (w_ff.dest == e_idx[k])) begin
            ovr_ff[k]      <= 1'b1;
            ovr_data_ff[k] <= w_rval;
         end
      end
   end

   // Data memory: write at commit.
   always_ff @(posedge clock) begin
      if (cm_mwe) begin
         dmem_mem[w_ff.maddr] <= w_ff.mval;
      end
   end

   // Data memory read as an item enters the writeback stage.
   always_ff @(posedge clock) begin
      if (e_move) begin
         w_ff         <= w_in;
         mraw_ff      <= dmem_mem[maddr];
         mrdv_ff      <= mvalid_ff[maddr];
         movr_ff      <= cm_mwe && (w_ff.maddr == maddr);
         movr_data_ff <= w_ff.mval;
      end
   end

   always_ff @(posedge clock) begin
      if (w_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_result = rsp_ff;

endmodule

// File: src/bie_checker.sv
// Port-level checks of the byte execute unit, bound to the top level.
// Uses assert_macros.svh and the field positions from bie_pkg.
`include "assert_macros.svh"

module bie_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bie_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   `BIE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `BIE_ASSERT_IMP(a_illegal_no_write, clock, reset, rsp_tvalid && rsp_tdata[bie_pkg::RSP_ILL_BIT], !rsp_tdata[bie_pkg::RSP_RW_BIT] && !rsp_tdata[bie_pkg::RSP_MW_BIT], "illegal opcode reported a write")
   `BIE_ASSERT_IMP(a_halt_flag, clock, reset, rsp_tvalid, rsp_tdata[bie_pkg::RSP_HALT_BIT] == (rsp_tdata[7:0] == bie_pkg::HALT_PC), "halt flag disagrees with next pc")
   `BIE_ASSERT_RST(a_reset_empty, clock, reset, !rsp_tvalid, "result valid right after reset")

endmodule

bind byte_isa_execute_unit bie_checker u_bie_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
